@@ design/riscv_integer_execute_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the integer execute unit
// Shared wrappers so every check reports the same way on the unit clock.
// ----------------------------------------------------------------------------
`ifndef RISCV_INTEGER_EXECUTE_UNIT_MACROS_SVH
`define RISCV_INTEGER_EXECUTE_UNIT_MACROS_SVH

// Checked only while the unit is out of reset.
`define RIEX_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every clock edge, reset cycles included.
`define RIEX_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ design/riex_pkg.sv @@
// ----------------------------------------------------------------------------
// riex_pkg
// Types and constants shared by the stages of the integer execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package riex_pkg;

    localparam int XLEN      = 64;
    localparam int OUT_AW    = 32;
    localparam int SHAMT_W   = 6;
    localparam int IMM_W     = 12;
    localparam int ACT_W     = 5;
    localparam int S_TDATA_W = 208;
    localparam int M_TDATA_W = 104;

    // Operation codes as they arrive on the input channel.
    localparam logic [ACT_W-1:0] ACT_ADDI  = 5'd0;
    localparam logic [ACT_W-1:0] ACT_SLTI  = 5'd1;
    localparam logic [ACT_W-1:0] ACT_SLTIU = 5'd2;
    localparam logic [ACT_W-1:0] ACT_XORI  = 5'd3;
    localparam logic [ACT_W-1:0] ACT_ORI   = 5'd4;
    localparam logic [ACT_W-1:0] ACT_ANDI  = 5'd5;
    localparam logic [ACT_W-1:0] ACT_SLLI  = 5'd6;
    localparam logic [ACT_W-1:0] ACT_SRLI  = 5'd7;
    localparam logic [ACT_W-1:0] ACT_SRAI  = 5'd8;
    localparam logic [ACT_W-1:0] ACT_ADD   = 5'd9;
    localparam logic [ACT_W-1:0] ACT_SUB   = 5'd10;
    localparam logic [ACT_W-1:0] ACT_SLL   = 5'd11;
    localparam logic [ACT_W-1:0] ACT_SLT   = 5'd12;
    localparam logic [ACT_W-1:0] ACT_SLTU  = 5'd13;
    localparam logic [ACT_W-1:0] ACT_XOR   = 5'd14;
    localparam logic [ACT_W-1:0] ACT_SRL   = 5'd15;
    localparam logic [ACT_W-1:0] ACT_SRA   = 5'd16;
    localparam logic [ACT_W-1:0] ACT_OR    = 5'd17;
    localparam logic [ACT_W-1:0] ACT_AND   = 5'd18;
    localparam logic [ACT_W-1:0] ACT_MEM   = 5'd19;
    localparam logic [ACT_W-1:0] ACT_BEQ   = 5'd20;
    localparam logic [ACT_W-1:0] ACT_BNE   = 5'd21;
    localparam logic [ACT_W-1:0] ACT_BLT   = 5'd22;
    localparam logic [ACT_W-1:0] ACT_BGE   = 5'd23;
    localparam logic [ACT_W-1:0] ACT_BLTU  = 5'd24;
    localparam logic [ACT_W-1:0] ACT_BGEU  = 5'd25;
    localparam logic [ACT_W-1:0] ACT_JAL   = 5'd26;
    localparam logic [ACT_W-1:0] ACT_JALR  = 5'd27;

    // Internal operation after decode; immediate and register forms merge.
    typedef enum logic [4:0] {
        OP_ADD,
        OP_SUB,
        OP_SLL,
        OP_SLT,
        OP_SLTU,
        OP_XOR,
        OP_SRL,
        OP_SRA,
        OP_OR,
        OP_AND,
        OP_BEQ,
        OP_BNE,
        OP_BLT,
        OP_BGE,
        OP_BLTU,
        OP_BGEU,
        OP_JAL,
        OP_JALR,
        OP_NOP
    } alu_op_t;

    typedef struct packed {
        alu_op_t             op;
        logic [XLEN-1:0]     opa;
        logic [XLEN-1:0]     opb;
        logic [SHAMT_W-1:0]  shamt;
        logic [XLEN-1:0]     ret_addr;
        logic [OUT_AW-1:0]   label;
    } dec_t;

    typedef struct packed {
        alu_op_t             op;
        logic [XLEN-1:0]     value;
        logic                cond;
        logic [XLEN-1:0]     ret_addr;
        logic [OUT_AW-1:0]   label;
    } exe_t;

endpackage

`default_nettype wire

@@ design/riex_decode.sv @@
// ----------------------------------------------------------------------------
// riex_decode
// First stage: maps the operation code, sign-extends the operands and
// prepares the second operand, shift amount and return address.
// ----------------------------------------------------------------------------
`default_nettype none

module riex_decode #(
    parameter int DATA_WIDTH = 64,
    parameter int ADDR_WIDTH = 32
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [riex_pkg::ACT_W-1:0]            action,
    input  wire logic signed [riex_pkg::XLEN-1:0]      operand_a,
    input  wire logic signed [riex_pkg::XLEN-1:0]      operand_b,
    input  wire logic signed [riex_pkg::IMM_W-1:0]     immediate,
    input  wire logic [riex_pkg::OUT_AW-1:0]           instr_address,
    input  wire logic [riex_pkg::OUT_AW-1:0]           label_target,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output riex_pkg::dec_t                             out_data
);

    localparam logic [riex_pkg::XLEN-1:0] DMASK = (DATA_WIDTH >= riex_pkg::XLEN) ? '1 :
        ((64'd1 << DATA_WIDTH) - 64'd1);
    localparam logic [riex_pkg::XLEN-1:0] AMASK = (ADDR_WIDTH >= riex_pkg::XLEN) ? '1 :
        ((64'd1 << ADDR_WIDTH) - 64'd1);
    localparam logic [riex_pkg::SHAMT_W-1:0] SHMASK = riex_pkg::SHAMT_W'(DATA_WIDTH - 1);

    logic                         valid_reg;
    riex_pkg::dec_t               data_reg;
    riex_pkg::dec_t               data_next;
    logic [riex_pkg::XLEN-1:0]    a_ext;
    logic [riex_pkg::XLEN-1:0]    b_ext;
    logic [riex_pkg::XLEN-1:0]    imm_ext;
    logic                         use_imm;

    // Operands are taken at DATA_WIDTH bits and sign-extended to the full word.
    assign a_ext   = (operand_a & DMASK) | ({riex_pkg::XLEN{operand_a[DATA_WIDTH-1]}} & ~DMASK);
    assign b_ext   = (operand_b & DMASK) | ({riex_pkg::XLEN{operand_b[DATA_WIDTH-1]}} & ~DMASK);
    assign imm_ext = {{(riex_pkg::XLEN-riex_pkg::IMM_W){immediate[riex_pkg::IMM_W-1]}},
                      immediate};

    always_comb begin
        data_next.op = riex_pkg::OP_NOP;
        use_imm      = 1'b0;
        case (action)
            riex_pkg::ACT_ADDI:  begin data_next.op = riex_pkg::OP_ADD;  use_imm = 1'b1; end
            riex_pkg::ACT_SLTI:  begin data_next.op = riex_pkg::OP_SLT;  use_imm = 1'b1; end
            riex_pkg::ACT_SLTIU: begin data_next.op = riex_pkg::OP_SLTU; use_imm = 1'b1; end
            riex_pkg::ACT_XORI:  begin data_next.op = riex_pkg::OP_XOR;  use_imm = 1'b1; end
            riex_pkg::ACT_ORI:   begin data_next.op = riex_pkg::OP_OR;   use_imm = 1'b1; end
            riex_pkg::ACT_ANDI:  begin data_next.op = riex_pkg::OP_AND;  use_imm = 1'b1; end
            riex_pkg::ACT_SLLI:  begin data_next.op = riex_pkg::OP_SLL;  use_imm = 1'b1; end
            riex_pkg::ACT_SRLI:  begin data_next.op = riex_pkg::OP_SRL;  use_imm = 1'b1; end
            riex_pkg::ACT_SRAI:  begin data_next.op = riex_pkg::OP_SRA;  use_imm = 1'b1; end
            riex_pkg::ACT_ADD:   data_next.op = riex_pkg::OP_ADD;
            riex_pkg::ACT_SUB:   data_next.op = riex_pkg::OP_SUB;
            riex_pkg::ACT_SLL:   data_next.op = riex_pkg::OP_SLL;
            riex_pkg::ACT_SLT:   data_next.op = riex_pkg::OP_SLT;
            riex_pkg::ACT_SLTU:  data_next.op = riex_pkg::OP_SLTU;
            riex_pkg::ACT_XOR:   data_next.op = riex_pkg::OP_XOR;
            riex_pkg::ACT_SRL:   data_next.op = riex_pkg::OP_SRL;
            riex_pkg::ACT_SRA:   data_next.op = riex_pkg::OP_SRA;
            riex_pkg::ACT_OR:    data_next.op = riex_pkg::OP_OR;
            riex_pkg::ACT_AND:   data_next.op = riex_pkg::OP_AND;
            // A memory access address is a plain base plus immediate.
            riex_pkg::ACT_MEM:   begin data_next.op = riex_pkg::OP_ADD;  use_imm = 1'b1; end
            riex_pkg::ACT_BEQ:   data_next.op = riex_pkg::OP_BEQ;
            riex_pkg::ACT_BNE:   data_next.op = riex_pkg::OP_BNE;
            riex_pkg::ACT_BLT:   data_next.op = riex_pkg::OP_BLT;
            riex_pkg::ACT_BGE:   data_next.op = riex_pkg::OP_BGE;
            riex_pkg::ACT_BLTU:  data_next.op = riex_pkg::OP_BLTU;
            riex_pkg::ACT_BGEU:  data_next.op = riex_pkg::OP_BGEU;
            riex_pkg::ACT_JAL:   data_next.op = riex_pkg::OP_JAL;
            riex_pkg::ACT_JALR:  begin data_next.op = riex_pkg::OP_JALR; use_imm = 1'b1; end
            default:             data_next.op = riex_pkg::OP_NOP;
        endcase

        data_next.opa      = a_ext;
        data_next.opb      = use_imm ? imm_ext : b_ext;
        data_next.shamt    = data_next.opb[riex_pkg::SHAMT_W-1:0] & SHMASK;
        data_next.ret_addr = (riex_pkg::XLEN'(instr_address) + riex_pkg::XLEN'(4)) & AMASK;
        data_next.label    = label_target;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

@@ design/riex_alu.sv @@
// ----------------------------------------------------------------------------
// riex_alu
// Second stage: adder, subtractor, shifter, logic unit and comparators.
// Produces the raw data value and the branch condition.
// ----------------------------------------------------------------------------
`default_nettype none

module riex_alu #(
    parameter int DATA_WIDTH = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  riex_pkg::dec_t           in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output riex_pkg::exe_t           out_data
);

    localparam logic [riex_pkg::XLEN-1:0] DMASK = (DATA_WIDTH >= riex_pkg::XLEN) ? '1 :
        ((64'd1 << DATA_WIDTH) - 64'd1);

    logic                         valid_reg;
    riex_pkg::exe_t               data_reg;
    riex_pkg::exe_t               data_next;
    logic [riex_pkg::XLEN-1:0]    sum;
    logic [riex_pkg::XLEN-1:0]    diff;
    logic [riex_pkg::XLEN-1:0]    sra_val;
    logic                         lt_s;
    logic                         lt_u;
    logic                         eq;

    assign sum     = in_data.opa + in_data.opb;
    assign diff    = in_data.opa - in_data.opb;
    assign sra_val = $signed(in_data.opa) >>> in_data.shamt;
    // Operands are sign-extended, so comparing full words matches a compare at
    // DATA_WIDTH bits for both signed and unsigned orders.
    assign lt_s    = $signed(in_data.opa) < $signed(in_data.opb);
    assign lt_u    = in_data.opa < in_data.opb;
    assign eq      = in_data.opa == in_data.opb;

    always_comb begin
        data_next.op       = in_data.op;
        data_next.ret_addr = in_data.ret_addr;
        data_next.label    = in_data.label;
        data_next.value    = '0;
        data_next.cond     = 1'b0;
        case (in_data.op)
            riex_pkg::OP_ADD:  data_next.value = sum;
            riex_pkg::OP_SUB:  data_next.value = diff;
            riex_pkg::OP_SLL:  data_next.value = in_data.opa << in_data.shamt;
            riex_pkg::OP_SLT:  data_next.value = {{(riex_pkg::XLEN-1){1'b0}}, lt_s};
            riex_pkg::OP_SLTU: data_next.value = {{(riex_pkg::XLEN-1){1'b0}}, lt_u};
            riex_pkg::OP_XOR:  data_next.value = in_data.opa ^ in_data.opb;
            riex_pkg::OP_SRL:  data_next.value = (in_data.opa & DMASK) >> in_data.shamt;
            riex_pkg::OP_SRA:  data_next.value = sra_val;
            riex_pkg::OP_OR:   data_next.value = in_data.opa | in_data.opb;
            riex_pkg::OP_AND:  data_next.value = in_data.opa & in_data.opb;
            riex_pkg::OP_BEQ:  data_next.cond  = eq;
            riex_pkg::OP_BNE:  data_next.cond  = !eq;
            riex_pkg::OP_BLT:  data_next.cond  = lt_s;
            riex_pkg::OP_BGE:  data_next.cond  = !lt_s;
            riex_pkg::OP_BLTU: data_next.cond  = lt_u;
            riex_pkg::OP_BGEU: data_next.cond  = !lt_u;
            riex_pkg::OP_JAL:  data_next.cond  = 1'b1;
            riex_pkg::OP_JALR: begin
                data_next.value = sum;
                data_next.cond  = 1'b1;
            end
            default: begin
                data_next.value = '0;
                data_next.cond  = 1'b0;
            end
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

@@ design/riex_resolve.sv @@
// ----------------------------------------------------------------------------
// riex_resolve
// Third stage and output register: picks the result word, sign-extends data
// values and forms the redirect flag and fetch target.
// ----------------------------------------------------------------------------
`default_nettype none

module riex_resolve #(
    parameter int DATA_WIDTH = 64,
    parameter int ADDR_WIDTH = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  riex_pkg::exe_t                     in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [riex_pkg::XLEN-1:0]          result,
    output logic                               redirect,
    output logic [riex_pkg::OUT_AW-1:0]        redirect_target
);

    localparam logic [riex_pkg::XLEN-1:0] DMASK = (DATA_WIDTH >= riex_pkg::XLEN) ? '1 :
        ((64'd1 << DATA_WIDTH) - 64'd1);
    localparam logic [riex_pkg::XLEN-1:0] AMASK = (ADDR_WIDTH >= riex_pkg::XLEN) ? '1 :
        ((64'd1 << ADDR_WIDTH) - 64'd1);
    localparam logic [riex_pkg::OUT_AW-1:0] TGT_MASK = AMASK[riex_pkg::OUT_AW-1:0];

    logic                           valid_reg;
    logic [riex_pkg::XLEN-1:0]      result_reg;
    logic [riex_pkg::XLEN-1:0]      result_next;
    logic                           redirect_reg;
    logic                           redirect_next;
    logic [riex_pkg::OUT_AW-1:0]    target_reg;
    logic [riex_pkg::OUT_AW-1:0]    target_next;
    logic [riex_pkg::XLEN-1:0]      value_ext;

    assign value_ext = (in_data.value & DMASK) |
                       ({riex_pkg::XLEN{in_data.value[DATA_WIDTH-1]}} & ~DMASK);

    always_comb begin
        redirect_next = in_data.cond;
        case (in_data.op)
            riex_pkg::OP_JAL: begin
                result_next = in_data.ret_addr;
                target_next = in_data.label & TGT_MASK;
            end
            riex_pkg::OP_JALR: begin
                // The jump target drops bit 0 of the unextended base plus offset.
                result_next = in_data.ret_addr;
                target_next = in_data.value[riex_pkg::OUT_AW-1:0] &
                              ~riex_pkg::OUT_AW'(1) & TGT_MASK;
            end
            default: begin
                result_next = value_ext;
                target_next = in_data.cond ? (in_data.label & TGT_MASK) : '0;
            end
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            result_reg   <= result_next;
            redirect_reg <= redirect_next;
            target_reg   <= target_next;
        end
    end

    assign out_valid       = valid_reg;
    assign result          = result_reg;
    assign redirect        = redirect_reg;
    assign redirect_target = target_reg;

endmodule

`default_nettype wire

@@ design/riscv_integer_execute_unit.sv @@
// ----------------------------------------------------------------------------
// riscv_integer_execute_unit
// Execute stage of a 64-bit integer pipeline: ALU, address adder and branch
// and jump resolution.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one decoded instruction per word: the operation code
// on s_tuser, the operands, immediate, instruction address and label target on
// s_tdata. The master channel returns one word per instruction: the result,
// the redirect flag and the redirect target.
// From acceptance to the output a word passes three registers: decode, compute
// and resolve each end in a register, the last one being the output register,
// and m_tvalid rises once the resolve register holds the word.
// Throughput is one word per cycle while m_tready stays high; each stage holds
// one word and passes it on as soon as the stage after it has room.
// Reset clears all valid bits; nothing is in flight afterwards.
// When the receiver stalls, the output word holds and the stages behind it
// keep filling until all three are full, then s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module riscv_integer_execute_unit #(
    parameter int DATA_WIDTH = 64,
    parameter int ADDR_WIDTH = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // operand_a[63:0], operand_b[127:64], immediate[139:128],
    // instr_address[171:140], label_target[203:172], zero pad [207:204]
    input  wire logic [riex_pkg::S_TDATA_W-1:0]      s_tdata,
    // action[4:0]
    input  wire logic [riex_pkg::ACT_W-1:0]          s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // result[63:0], redirect[64], redirect_target[96:65], zero pad [103:97]
    output logic [riex_pkg::M_TDATA_W-1:0]           m_tdata
);

    logic                           dec_valid;
    logic                           dec_ready;
    riex_pkg::dec_t                 dec_data;
    logic                           exe_valid;
    logic                           exe_ready;
    riex_pkg::exe_t                 exe_data;
    logic [riex_pkg::XLEN-1:0]      result;
    logic                           redirect;
    logic [riex_pkg::OUT_AW-1:0]    redirect_target;

    riex_decode #(
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_decode (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .action        (s_tuser),
        .operand_a     (s_tdata[63:0]),
        .operand_b     (s_tdata[127:64]),
        .immediate     (s_tdata[139:128]),
        .instr_address (s_tdata[171:140]),
        .label_target  (s_tdata[203:172]),
        .out_valid     (dec_valid),
        .out_ready     (dec_ready),
        .out_data      (dec_data)
    );

    riex_alu #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_alu (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (exe_valid),
        .out_ready (exe_ready),
        .out_data  (exe_data)
    );

    riex_resolve #(
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_resolve (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (exe_valid),
        .in_ready        (exe_ready),
        .in_data         (exe_data),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .result          (result),
        .redirect        (redirect),
        .redirect_target (redirect_target)
    );

    assign m_tdata = {7'b0, redirect_target, redirect, result};

endmodule

`default_nettype wire

@@ design/riex_checker.sv @@
// ----------------------------------------------------------------------------
// riex_checker
// Port-level checks for the integer execute unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "riscv_integer_execute_unit_macros.svh"

module riex_checker (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tready,
    input  wire logic                                m_tvalid,
    input  wire logic                                m_tready,
    input  wire logic [riex_pkg::M_TDATA_W-1:0]      m_tdata
);

    // A word just accepted must pass all three registers; none can show right after reset.
    `RIEX_ASSERT_ALWAYS(a_no_early_word, (!aresetn ##1 aresetn) |=> (!m_tvalid ##1 !m_tvalid), "result word appeared sooner than the pipeline depth allows")

    // With the receiver taking words, no stage can be blocked.
    `RIEX_ASSERT_ALWAYS(a_flow_through, m_tready |-> s_tready, "input stalled while the output was draining")

    // Without a redirect the target and the pad bits are zero.
    `RIEX_ASSERT(a_target_clear, (m_tvalid && !m_tdata[64]) |-> (m_tdata[103:65] == '0), "redirect target set on a word without redirect")

    `RIEX_ASSERT(a_hold_on_stall, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "output word changed while stalled")

endmodule

bind riscv_integer_execute_unit riex_checker u_checker (.*);

`default_nettype wire

@@ dv/tb_riscv_integer_execute_unit.sv @@
// ----------------------------------------------------------------------------
// tb_riscv_integer_execute_unit
// Self-checking bench for the integer execute unit. It computes the expected
// result, redirect flag and redirect target of every accepted word and checks
// them against the output stream in order, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_riscv_integer_execute_unit;

    localparam logic [riex_pkg::ACT_W-1:0] NOP_ACTION  = 5'd28;
    localparam logic [riex_pkg::ACT_W-1:0] LAST_ACTION = 5'd31;
    localparam logic [riex_pkg::XLEN-1:0]  INT_MIN     = 64'h8000_0000_0000_0000;
    localparam logic [riex_pkg::XLEN-1:0]  INT_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [riex_pkg::XLEN-1:0]  ALL_ONES    = '1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    // Input word, lowest field last.
    typedef struct packed {
        logic [3:0]                  pad;
        logic [riex_pkg::OUT_AW-1:0] lbl;
        logic [riex_pkg::OUT_AW-1:0] pc;
        logic [riex_pkg::IMM_W-1:0]  imm;
        logic [riex_pkg::XLEN-1:0]   opb;
        logic [riex_pkg::XLEN-1:0]   opa;
    } instr_word_t;

    typedef struct packed {
        logic [6:0]                  pad;
        logic [riex_pkg::OUT_AW-1:0] target;
        logic                        redirect;
        logic [riex_pkg::XLEN-1:0]   result;
    } exec_outcome_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    instr_word_t                    s_word   = '0;
    logic [riex_pkg::ACT_W-1:0]     s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [riex_pkg::M_TDATA_W-1:0] m_tdata;

    exec_outcome_t pending_results[$];
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_off_left  = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;

    riscv_integer_execute_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_word),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic logic [riex_pkg::XLEN-1:0] alu_value(
            logic [riex_pkg::ACT_W-1:0] op, logic [riex_pkg::XLEN-1:0] x,
            logic [riex_pkg::XLEN-1:0] y);
        logic [riex_pkg::SHAMT_W-1:0] sh;
        sh = y[riex_pkg::SHAMT_W-1:0];
        case (op)
            riex_pkg::ACT_ADD:  return x + y;
            riex_pkg::ACT_SUB:  return x - y;
            riex_pkg::ACT_SLL:  return x << sh;
            riex_pkg::ACT_SLT:  return {63'd0, $signed(x) < $signed(y)};
            riex_pkg::ACT_SLTU: return {63'd0, x < y};
            riex_pkg::ACT_XOR:  return x ^ y;
            riex_pkg::ACT_SRL:  return x >> sh;
            riex_pkg::ACT_SRA:  return $signed(x) >>> sh;
            riex_pkg::ACT_OR:   return x | y;
            riex_pkg::ACT_AND:  return x & y;
            default:            return '0;
        endcase
    endfunction

    function automatic exec_outcome_t predict_execute(logic [riex_pkg::ACT_W-1:0] act,
                                                      instr_word_t w);
        exec_outcome_t o;
        logic [riex_pkg::XLEN-1:0] imm;
        logic [riex_pkg::XLEN-1:0] jump_sum;
        logic [riex_pkg::OUT_AW-1:0] ret_addr;
        logic taken;
        o = '0;
        taken = 1'b0;
        imm = {{(riex_pkg::XLEN-riex_pkg::IMM_W){w.imm[riex_pkg::IMM_W-1]}}, w.imm};
        jump_sum = w.opa + imm;
        ret_addr = w.pc + 32'd4;
        case (act)
            riex_pkg::ACT_ADDI:  o.result = alu_value(riex_pkg::ACT_ADD, w.opa, imm);
            riex_pkg::ACT_SLTI:  o.result = alu_value(riex_pkg::ACT_SLT, w.opa, imm);
            riex_pkg::ACT_SLTIU: o.result = alu_value(riex_pkg::ACT_SLTU, w.opa, imm);
            riex_pkg::ACT_XORI:  o.result = alu_value(riex_pkg::ACT_XOR, w.opa, imm);
            riex_pkg::ACT_ORI:   o.result = alu_value(riex_pkg::ACT_OR, w.opa, imm);
            riex_pkg::ACT_ANDI:  o.result = alu_value(riex_pkg::ACT_AND, w.opa, imm);
            riex_pkg::ACT_SLLI:  o.result = alu_value(riex_pkg::ACT_SLL, w.opa, imm);
            riex_pkg::ACT_SRLI:  o.result = alu_value(riex_pkg::ACT_SRL, w.opa, imm);
            riex_pkg::ACT_SRAI:  o.result = alu_value(riex_pkg::ACT_SRA, w.opa, imm);
            riex_pkg::ACT_ADD, riex_pkg::ACT_SUB, riex_pkg::ACT_SLL, riex_pkg::ACT_SLT,
            riex_pkg::ACT_SLTU, riex_pkg::ACT_XOR, riex_pkg::ACT_SRL, riex_pkg::ACT_SRA,
            riex_pkg::ACT_OR, riex_pkg::ACT_AND:
                o.result = alu_value(act, w.opa, w.opb);
            riex_pkg::ACT_MEM:   o.result = jump_sum;
            riex_pkg::ACT_BEQ:   taken = (w.opa == w.opb);
            riex_pkg::ACT_BNE:   taken = (w.opa != w.opb);
            riex_pkg::ACT_BLT:   taken = ($signed(w.opa) < $signed(w.opb));
            riex_pkg::ACT_BGE:   taken = !($signed(w.opa) < $signed(w.opb));
            riex_pkg::ACT_BLTU:  taken = (w.opa < w.opb);
            riex_pkg::ACT_BGEU:  taken = !(w.opa < w.opb);
            riex_pkg::ACT_JAL: begin
                o.result = {32'd0, ret_addr};
                o.redirect = 1'b1;
                o.target = w.lbl;
            end
            riex_pkg::ACT_JALR: begin
                // The jump target drops bit 0 and everything above the address width.
                o.result = {32'd0, ret_addr};
                o.redirect = 1'b1;
                o.target = {jump_sum[riex_pkg::OUT_AW-1:1], 1'b0};
            end
            default: ;
        endcase
        if (taken) begin
            o.redirect = 1'b1;
            o.target = w.lbl;
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [riex_pkg::XLEN-1:0] got,
                                   logic [riex_pkg::XLEN-1:0] want);
        mismatch_count++;
        $display("%0t: %s mismatch, got %h expected %h", $time, what, got, want);
    endtask

    // Checks each output word against the oldest expectation, then records
    // the expectation of any word accepted at the same edge.
    always @(posedge aclk) begin : scoreboard
        exec_outcome_t want;
        exec_outcome_t got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected output word", got.result, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.result !== want.result)
                        report_mismatch("result", got.result, want.result);
                    if (got.redirect !== want.redirect)
                        report_mismatch("redirect", 64'(got.redirect), 64'(want.redirect));
                    if (got.target !== want.target)
                        report_mismatch("redirect_target", 64'(got.target), 64'(want.target));
                end
            end
            if (s_tvalid && s_tready)
                pending_results.insert(pending_results.size(),
                                       predict_execute(s_tuser, s_word));
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // A hold-off, when requested, overrides the random stalls.
    always @(negedge aclk) begin
        if (hold_off_left > 0) begin
            hold_off_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_instr(input logic [riex_pkg::ACT_W-1:0] act,
                              input logic [riex_pkg::XLEN-1:0] a,
                              input logic [riex_pkg::XLEN-1:0] b,
                              input logic [riex_pkg::IMM_W-1:0] imm,
                              input logic [riex_pkg::OUT_AW-1:0] pc,
                              input logic [riex_pkg::OUT_AW-1:0] lbl);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_word   <= '{pad: '0, lbl: lbl, pc: pc, imm: imm, opb: b, opa: a};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic wait_for_results;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [riex_pkg::XLEN-1:0] random_operand;
        case ($urandom_range(7))
            0: return '0;
            1: return ALL_ONES;
            2: return INT_MIN;
            3: return INT_MAX;
            4: return 64'($urandom_range(70));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_random_instr;
        logic [riex_pkg::ACT_W-1:0] act;
        logic [riex_pkg::XLEN-1:0] a;
        logic [riex_pkg::XLEN-1:0] b;
        logic [riex_pkg::IMM_W-1:0] imm;
        act = riex_pkg::ACT_W'($urandom_range(NOP_ACTION));
        a = random_operand();
        b = random_operand();
        // Equal operands make the equality branches go both ways.
        if (act >= riex_pkg::ACT_BEQ && act <= riex_pkg::ACT_BGEU && $urandom_range(3) == 0)
            b = a;
        case ($urandom_range(7))
            0: imm = 12'h800;
            1: imm = 12'h7FF;
            default: imm = riex_pkg::IMM_W'($urandom);
        endcase
        send_instr(act, a, b, imm, $urandom, $urandom);
    endtask

    task automatic test_every_action;
        logic [riex_pkg::XLEN-1:0] pool[5];
        pool = '{'0, 64'd1, ALL_ONES, INT_MIN, INT_MAX};
        for (int code = 0; code <= LAST_ACTION; code++)
            send_instr(riex_pkg::ACT_W'(code), pool[code % 5], pool[(code * 3 + 1) % 5],
                       code[0] ? 12'h7FF : 12'h800, 32'hFFFF_FFFC, 32'hFFFF_FFFF);
    endtask

    task automatic test_corner_cases;
        // Shift amounts wider than six bits are masked.
        send_instr(riex_pkg::ACT_SLLI, 64'd1, '0, 12'h7FF, 32'h0, 32'h0);
        send_instr(riex_pkg::ACT_SRAI, INT_MIN, '0, 12'h43F, 32'h0, 32'h0);
        send_instr(riex_pkg::ACT_SRL, ALL_ONES, 64'hFFFF_FFFF_FFFF_FFC1, '0, 32'h0, 32'h0);
        send_instr(riex_pkg::ACT_SRA, INT_MIN, 64'd64, '0, 32'h0, 32'h0);
        send_instr(riex_pkg::ACT_SLTU, INT_MIN, INT_MAX, '0, 32'h0, 32'h0);
        send_instr(riex_pkg::ACT_ADD, INT_MAX, 64'd1, '0, 32'h0, 32'h0);
        send_instr(riex_pkg::ACT_MEM, '0, '0, 12'h800, 32'h0, 32'h0);
        send_instr(riex_pkg::ACT_BEQ, INT_MIN, INT_MIN, '0, 32'h1234_5678, 32'hFFFF_FFFF);
        send_instr(riex_pkg::ACT_BGEU, '0, ALL_ONES, '0, 32'h1234_5678, 32'hFFFF_FFFF);
        // The return address wraps at the address width; odd JALR targets lose bit 0.
        send_instr(riex_pkg::ACT_JAL, '0, '0, '0, 32'hFFFF_FFFC, 32'h8000_0000);
        send_instr(riex_pkg::ACT_JALR, 64'h1_0000_0003, '0, '0, 32'hFFFF_FFFE, 32'h0);
        send_instr(riex_pkg::ACT_JALR, '0, '0, 12'hFFF, 32'h0, 32'h0);
    endtask

    task automatic test_random_stream(input int count);
        repeat (count) send_random_instr();
    endtask

    // The receiver stops long enough for the pipeline to fill and refuse input.
    task automatic test_backpressure;
        hold_off_left = 150;
        repeat (30) send_random_instr();
        wait_for_results();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct  = 37;
        recv_stall_pct = 62;
        test_every_action();
        test_corner_cases();
        test_random_stream(200);

        send_idle_pct  = 62;
        recv_stall_pct = 37;
        test_random_stream(200);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_stream(150);
        test_backpressure();
        test_random_stream(20);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/riex_pkg.sv
design/riex_decode.sv
design/riex_alu.sv
design/riex_resolve.sv
design/riscv_integer_execute_unit.sv
design/riex_checker.sv
dv/tb_riscv_integer_execute_unit.sv
